FILE: rtl/core/bkp_pkg.sv
`timescale 1ns / 1ps

package bkp_pkg;

  // Coordinate width of the pixel row and column fields
  localparam int COORD_BITS = 12;

  localparam int DEPTH_W    = 16;
  localparam int CENTER_W   = 16;
  localparam int INV_W      = 24;
  localparam int POINT_W    = 32;
  localparam int FRAC_SHIFT = 28;

  // Offset (coord << 4) - centre, signed, and its magnitude
  localparam int SHIFT_W = COORD_BITS + 4;
  localparam int OFF_W   = ((SHIFT_W > CENTER_W) ? SHIFT_W : CENTER_W) + 1;
  localparam int MAG_W   = OFF_W - 1;
  // magnitude * depth, then split in two halves for the reciprocal multiply
  localparam int PROD_W  = MAG_W + DEPTH_W;
  localparam int LO_W    = PROD_W / 2;
  localparam int HI_W    = PROD_W - LO_W;
  localparam int FULL_W  = PROD_W + INV_W;
  // integer part after rounding, plus one bit for the rounding carry
  localparam int IP_W    = FULL_W - FRAC_SHIFT + 1;
  localparam int IPX_W   = (IP_W > POINT_W + 1) ? IP_W : POINT_W + 1;

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  localparam logic [DEPTH_W-1:0]  RST_MIN_DEPTH  = 16'd1000;
  localparam logic [DEPTH_W-1:0]  RST_MAX_DEPTH  = 16'd10000;
  localparam logic [CENTER_W-1:0] RST_CENTER_COL = 16'd5120;
  localparam logic [CENTER_W-1:0] RST_CENTER_ROW = 16'd3840;
  localparam logic [INV_W-1:0]    RST_INV_FOCAL  = 24'd27280;

  typedef enum logic [2:0] {
    REG_MIN_DEPTH  = 3'd0,
    REG_MAX_DEPTH  = 3'd1,
    REG_CENTER_COL = 3'd2,
    REG_CENTER_ROW = 3'd3,
    REG_INV_FX     = 3'd4,
    REG_INV_FY     = 3'd5,
    REG_ORGANIZED  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [DEPTH_W-1:0]  min_depth;
    logic [DEPTH_W-1:0]  max_depth;
    logic [CENTER_W-1:0] center_col_q4;
    logic [CENTER_W-1:0] center_row_q4;
    logic [INV_W-1:0]    inv_focal_x;
    logic [INV_W-1:0]    inv_focal_y;
    logic                organized;
  } bkp_cfg_t;

  typedef struct packed {
    logic [DEPTH_W-1:0]    depth;
    logic [COORD_BITS-1:0] pix_row;
    logic [COORD_BITS-1:0] pix_col;
  } in_item_t;

  typedef struct packed {
    logic signed [POINT_W-1:0] point_x;
    logic signed [POINT_W-1:0] point_y;
    logic [DEPTH_W-1:0]        point_z;
    logic                      point_valid;
  } out_item_t;

  // Load enables, one for each pipeline stage and the output register
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic so;
  } stage_en_t;

endpackage

FILE: rtl/core/bkp_cfg_regs.sv
`timescale 1ns / 1ps

module bkp_cfg_regs import bkp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output bkp_cfg_t          cfg_o
);

  bkp_cfg_t cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[APB_AW-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_MIN_DEPTH:  cfg_d.min_depth     = pwdata[DEPTH_W-1:0];
        REG_MAX_DEPTH:  cfg_d.max_depth     = pwdata[DEPTH_W-1:0];
        REG_CENTER_COL: cfg_d.center_col_q4 = pwdata[CENTER_W-1:0];
        REG_CENTER_ROW: cfg_d.center_row_q4 = pwdata[CENTER_W-1:0];
        REG_INV_FX:     cfg_d.inv_focal_x   = pwdata[INV_W-1:0];
        REG_INV_FY:     cfg_d.inv_focal_y   = pwdata[INV_W-1:0];
        REG_ORGANIZED:  cfg_d.organized     = pwdata[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MIN_DEPTH:  prdata = APB_DW'(cfg_q.min_depth);
      REG_MAX_DEPTH:  prdata = APB_DW'(cfg_q.max_depth);
      REG_CENTER_COL: prdata = APB_DW'(cfg_q.center_col_q4);
      REG_CENTER_ROW: prdata = APB_DW'(cfg_q.center_row_q4);
      REG_INV_FX:     prdata = APB_DW'(cfg_q.inv_focal_x);
      REG_INV_FY:     prdata = APB_DW'(cfg_q.inv_focal_y);
      REG_ORGANIZED:  prdata = APB_DW'(cfg_q.organized);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_depth     <= RST_MIN_DEPTH;
      cfg_q.max_depth     <= RST_MAX_DEPTH;
      cfg_q.center_col_q4 <= RST_CENTER_COL;
      cfg_q.center_row_q4 <= RST_CENTER_ROW;
      cfg_q.inv_focal_x   <= RST_INV_FOCAL;
      cfg_q.inv_focal_y   <= RST_INV_FOCAL;
      cfg_q.organized     <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/bkp_axis.sv
`timescale 1ns / 1ps

// One axis: floor(((coord << 4) - centre) * depth * inv / 2^28), saturated.
// Stage 1 offset, stage 2 depth product, stage 3 split reciprocal product,
// stage 4 sum and rounding; the sign fix-up is left for the output register.
module bkp_axis import bkp_pkg::*; (
  input  logic                      clk_i,
  input  stage_en_t                 en_i,
  input  logic [COORD_BITS-1:0]     coord_i,
  input  logic [CENTER_W-1:0]       center_i,
  input  logic [INV_W-1:0]          inv_i,
  input  logic [DEPTH_W-1:0]        depth_i,   // stage 1 depth
  output logic signed [POINT_W-1:0] value_o
);

  localparam logic [FULL_W:0] RND = (FULL_W + 1)'((64'd1 << FRAC_SHIFT) - 64'd1);
  localparam logic [IPX_W-1:0] POS_LIM = IPX_W'(32'h7FFF_FFFF);
  localparam logic [IPX_W-1:0] NEG_LIM = IPX_W'(32'h8000_0000);

  logic [OFF_W-1:0] shifted, off, off_abs;
  logic             neg_d;

  logic [MAG_W-1:0]      mag_q;
  logic [PROD_W-1:0]     prod_d, prod_q;
  logic [LO_W+INV_W-1:0] plo_d, plo_q;
  logic [HI_W+INV_W-1:0] phi_d, phi_q;
  logic [FULL_W:0]       sum_d;
  logic [IP_W-1:0]       ip_q;
  logic [IPX_W-1:0]      ipx;
  logic                  neg1_q, neg2_q, neg3_q, neg4_q;

  assign shifted = OFF_W'({coord_i, 4'b0000});
  assign off     = shifted - OFF_W'(center_i);
  assign neg_d   = off[OFF_W-1];
  assign off_abs = neg_d ? (~off + OFF_W'(1)) : off;

  assign prod_d = mag_q * depth_i;
  assign plo_d  = prod_q[LO_W-1:0] * inv_i;
  assign phi_d  = prod_q[PROD_W-1:LO_W] * inv_i;
  // negative values round the magnitude up so the result floors
  assign sum_d  = {1'b0, phi_q, {LO_W{1'b0}}} + (FULL_W + 1)'(plo_q)
                + (neg3_q ? RND : '0);

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      mag_q  <= off_abs[MAG_W-1:0];
      neg1_q <= neg_d;
    end
    if (en_i.s2) begin
      prod_q <= prod_d;
      neg2_q <= neg1_q;
    end
    if (en_i.s3) begin
      plo_q  <= plo_d;
      phi_q  <= phi_d;
      neg3_q <= neg2_q;
    end
    if (en_i.s4) begin
      ip_q   <= sum_d[FULL_W:FRAC_SHIFT];
      neg4_q <= neg3_q;
    end
  end

  assign ipx = IPX_W'(ip_q);

  always_comb begin
    if (!neg4_q) begin
      value_o = (ipx > POS_LIM) ? 32'sh7FFF_FFFF : signed'(ipx[POINT_W-1:0]);
    end else begin
      value_o = (ipx > NEG_LIM) ? 32'sh8000_0000 : signed'(~ipx[POINT_W-1:0] + 32'd1);
    end
  end

endmodule

FILE: rtl/core/depth_to_point_backproject_core.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   in_item_i  (depth, pix_row, pix_col)
// out      output     out_valid_o / out_stall_i out_item_o (point_x/y/z, point_valid)
// cfg      input      APB psel/penable/pwrite   7 registers at 4*i, pready always high
//
// One item per cycle unless in_stall_o is high; out_valid_o rises once the accepted item
// has passed the offset, depth-product, split-reciprocal, sum and output stages.
// Reset loads the register defaults and empties the pipeline.
// A stall holds only full stages; bubbles are squeezed out, so in_stall_o
// rises only once every stage holds an item.
// In unorganized mode a rejected item is dropped at entry and leaves a bubble.
module depth_to_point_backproject_core import bkp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_item_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  bkp_cfg_t  cfg;
  stage_en_t en;

  logic [3:0] vld_q;
  logic [3:0] pass_q;
  logic [DEPTH_W-1:0] depth1_q, depth2_q, depth3_q, depth4_q;
  logic       out_valid_q;
  out_item_t  out_q;
  logic       pass_d, keep_d;
  logic signed [POINT_W-1:0] x_val, y_val;

  bkp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // a stage loads when it is empty or the next one loads
  assign en.so = !out_valid_q || !out_stall_i;
  assign en.s4 = !vld_q[3] || en.so;
  assign en.s3 = !vld_q[2] || en.s4;
  assign en.s2 = !vld_q[1] || en.s3;
  assign en.s1 = !vld_q[0] || en.s2;

  assign in_stall_o = !en.s1;

  assign pass_d = (in_item_i.depth > cfg.min_depth) && (in_item_i.depth < cfg.max_depth);
  assign keep_d = in_valid_i && (pass_d || cfg.organized);

  bkp_axis u_axis_x (
    .clk_i    (clk_i),
    .en_i     (en),
    .coord_i  (in_item_i.pix_col),
    .center_i (cfg.center_col_q4),
    .inv_i    (cfg.inv_focal_x),
    .depth_i  (depth1_q),
    .value_o  (x_val)
  );

  bkp_axis u_axis_y (
    .clk_i    (clk_i),
    .en_i     (en),
    .coord_i  (in_item_i.pix_row),
    .center_i (cfg.center_row_q4),
    .inv_i    (cfg.inv_focal_y),
    .depth_i  (depth1_q),
    .value_o  (y_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (en.s1) vld_q[0] <= keep_d;
      if (en.s2) vld_q[1] <= vld_q[0];
      if (en.s3) vld_q[2] <= vld_q[1];
      if (en.s4) vld_q[3] <= vld_q[2];
      if (en.so) out_valid_q <= vld_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en.s1) begin
      depth1_q  <= in_item_i.depth;
      pass_q[0] <= pass_d;
    end
    if (en.s2) begin
      depth2_q  <= depth1_q;
      pass_q[1] <= pass_q[0];
    end
    if (en.s3) begin
      depth3_q  <= depth2_q;
      pass_q[2] <= pass_q[1];
    end
    if (en.s4) begin
      depth4_q  <= depth3_q;
      pass_q[3] <= pass_q[2];
    end
    if (en.so) begin
      // rejected items go out flagged and zeroed
      out_q.point_x     <= pass_q[3] ? x_val : '0;
      out_q.point_y     <= pass_q[3] ? y_val : '0;
      out_q.point_z     <= pass_q[3] ? depth4_q : '0;
      out_q.point_valid <= pass_q[3];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef ASSERT_OFF
  a_invalid_zeroed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.point_valid |->
      out_item_o.point_x == 0 && out_item_o.point_y == 0 && out_item_o.point_z == 0)
    else $error("rejected item carries non-zero coordinates");

  a_valid_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.point_valid |-> out_item_o.point_z != 0)
    else $error("passing item with zero depth");

  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_stall_i)
    else $error("input stalled without output back-pressure");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !vld_q[3] |=> !out_valid_o)
    else $error("output item repeated after being taken");
`endif

endmodule
